>>> hdl/wrsp_pkg.sv
package wrsp_pkg;

    typedef enum logic [3:0] {
        P_RIFF, P_RSIZE, P_WAVE, P_HDR, P_FMT, P_FACT, P_DATA, P_SKIP, P_PAD, P_DEAD
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NO_RIFF  = 3'd1,
        ERR_NO_WAVE  = 3'd2,
        ERR_FMT_SIZE = 3'd3,
        ERR_NO_FMT   = 3'd4,
        ERR_FORMAT   = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        C_IDLE, C_DIV, C_OUT_S, C_OUT_R
    } t_ctl_state;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FORMAT_PCM   = 16'd1;
    localparam logic [15:0] FORMAT_FLOAT = 16'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;      // process the byte on the file-byte input
        logic div_start; // load the length divider
        logic div_step;  // one restoring step of the divider
        logic clear;     // return the parser to its reset state
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sample_hit; // the stepped byte completed a sample
        logic div_done;
    } t_status;

endpackage

>>> hdl/wrsp_ctrl.sv
module wrsp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_in_ready,
    input  logic              i_final,
    output logic              o_valid,
    input  logic              i_out_ready,
    output logic              o_kind,
    output wrsp_pkg::t_cmd    o_cmd,
    input  wrsp_pkg::t_status i_status
);
    import wrsp_pkg::*;

    t_ctl_state r_state, n_state;
    logic       r_final, n_final;
    logic       acc;

    assign acc = i_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_final = r_final;
        unique case (r_state)
            C_IDLE: begin
                if (acc) begin
                    n_final = i_final;
                    if (i_status.sample_hit) begin
                        n_state = C_OUT_S;
                    end else if (i_final) begin
                        n_state = C_DIV;
                    end
                end
            end
            C_OUT_S: begin
                if (i_out_ready) begin
                    n_state = r_final ? C_DIV : C_IDLE;
                end
            end
            C_DIV: begin
                if (i_status.div_done) begin
                    n_state = C_OUT_R;
                end
            end
            C_OUT_R: begin
                if (i_out_ready) begin
                    n_state = C_IDLE;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready    = 1'b0;
        o_valid       = 1'b0;
        o_kind        = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            C_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.step    = acc;
                o_cmd.div_start = acc && i_final;
            end
            C_OUT_S: begin
                o_valid = 1'b1;
            end
            C_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            C_OUT_R: begin
                o_valid   = 1'b1;
                o_kind    = 1'b1;
                o_cmd.clear = i_out_ready;
            end
            default: ;
        endcase
    end

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_in_ready) else $error("input taken while a result waits");
    a_report_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_DIV && i_status.div_done) |=> (o_valid && o_kind))
        else $error("report missing after division");
    a_clear_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> (o_valid && o_kind)) else $error("clear outside report");

endmodule

>>> hdl/wrsp_dp.sv
module wrsp_dp #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_selected_channel,
    input  logic [7:0]        i_file_byte,
    input  wrsp_pkg::t_cmd    i_cmd,
    output wrsp_pkg::t_status o_status,
    output logic [31:0]       o_sample_word,
    output logic              o_sample_is_float,
    output logic [2:0]        o_error_code,
    output logic [31:0]       o_sample_length
);
    import wrsp_pkg::*;

    localparam int CAP = SAMPLE_WIDTH / 8;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_idx, n_idx;
    logic [31:0] r_tag, n_tag;
    logic [32:0] r_left, n_left;
    logic        r_pad, n_pad;
    logic [15:0] r_ftag, n_ftag, r_chan, n_chan, r_blk, n_blk, r_bits, n_bits;
    logic        r_fmt_seen, n_fmt_seen, r_fact_seen, n_fact_seen;
    logic [31:0] r_fact, n_fact, r_total, n_total;
    logic [15:0] r_pos, n_pos;
    logic [31:0] r_asm, n_asm;
    logic [2:0]  r_err, n_err;
    logic [31:0] r_word;
    logic        r_flt;

    // Sample geometry: all narrow multiply/compare, sequential byte context.
    logic [13:0] nb;
    logic [31:0] off;
    logic [32:0] off_end;
    logic [31:0] kk;
    logic        in_sample, last_k;
    logic [31:0] sx;
    logic [5:0]  kept_bits;
    logic [31:0] size32, sum;
    logic [32:0] left_dec;
    logic        hit;

    assign nb        = 14'((17'(r_bits) + 17'd7) >> 3);
    assign off       = 32'(i_selected_channel) * 32'(nb);
    assign off_end   = 33'(off) + 33'(nb);
    assign kk        = 32'(r_pos) - off;
    assign in_sample = (r_blk != 16'd0) && (nb != 14'd0) && (off_end <= 33'(r_blk))
                       && (32'(r_pos) >= off) && (33'(r_pos) < off_end);
    assign last_k    = (kk == 32'(nb) - 32'd1);
    assign left_dec  = r_left - 33'd1;
    assign kept_bits = (32'(nb) < 32'(CAP)) ? 6'(nb * 8) : 6'(CAP * 8 % 64);

    always_comb begin
        logic [31:0] m;
        m  = 32'd0;
        sx = n_asm;
        if (kept_bits != 6'd0 && kept_bits < 6'd32) begin
            m  = 32'd1 << (kept_bits - 6'd1);
            sx = ((n_asm & ((m << 1) - 32'd1)) ^ m) - m;
        end
    end

    always_comb begin
        n_phase = r_phase; n_idx = r_idx; n_tag = r_tag; n_left = r_left; n_pad = r_pad;
        n_ftag = r_ftag; n_chan = r_chan; n_blk = r_blk; n_bits = r_bits;
        n_fmt_seen = r_fmt_seen; n_fact_seen = r_fact_seen; n_fact = r_fact;
        n_total = r_total; n_pos = r_pos; n_asm = r_asm; n_err = r_err;
        hit = 1'b0;
        size32 = r_left[31:0];
        sum = r_total + size32;
        unique case (r_phase)
            P_RIFF, P_WAVE: begin
                n_tag = r_tag | (32'(i_file_byte) << {r_idx[1:0], 3'b000});
                if (r_idx >= 5'd3) begin
                    if (r_phase == P_RIFF && n_tag != TAG_RIFF) begin
                        n_err = ERR_NO_RIFF; n_phase = P_DEAD;
                    end else if (r_phase == P_WAVE && n_tag != TAG_WAVE) begin
                        n_err = ERR_NO_WAVE; n_phase = P_DEAD;
                    end else begin
                        n_phase = (r_phase == P_RIFF) ? P_RSIZE : P_HDR;
                        n_tag = '0; n_idx = '0;
                    end
                end else n_idx = r_idx + 5'd1;
            end
            P_RSIZE: begin
                if (r_idx >= 5'd3) begin
                    n_idx = '0; n_tag = '0; n_phase = P_WAVE;
                end else n_idx = r_idx + 5'd1;
            end
            P_HDR: begin
                if (r_idx == 5'd0) begin
                    n_tag = 32'(i_file_byte);
                    n_left = '0;
                end else if (r_idx < 5'd4) begin
                    n_tag = r_tag | (32'(i_file_byte) << {r_idx[1:0], 3'b000});
                end else begin
                    n_left = r_left | (33'(i_file_byte) << {r_idx[1:0], 3'b000});
                end
                n_idx = r_idx + 5'd1;
                if (r_idx >= 5'd7) begin
                    n_idx = '0;
                    n_pad = n_left[0];
                    size32 = n_left[31:0];
                    sum = r_total + size32;
                    if (r_tag == TAG_FMT) begin
                        if (size32 != 32'd16 && size32 != 32'd18 && size32 != 32'd40) begin
                            n_err = ERR_FMT_SIZE; n_phase = P_DEAD;
                        end else begin
                            n_fmt_seen = 1'b1; n_phase = P_FMT;
                        end
                    end else if (r_tag == TAG_FACT) begin
                        n_fact_seen = 1'b1; n_fact = '0;
                        n_phase = (size32 == 32'd0) ? (n_pad ? P_PAD : P_HDR) : P_FACT;
                    end else if (r_tag == TAG_DATA) begin
                        if (!r_fmt_seen) begin
                            n_err = ERR_NO_FMT; n_phase = P_DEAD;
                        end else if (r_ftag != FORMAT_PCM && r_ftag != FORMAT_FLOAT) begin
                            n_err = ERR_FORMAT; n_phase = P_DEAD;
                        end else begin
                            n_total = (sum < r_total) ? 32'hFFFF_FFFF : sum;
                            n_pos = '0;
                            n_phase = (size32 == 32'd0) ? (n_pad ? P_PAD : P_HDR) : P_DATA;
                        end
                    end else begin
                        n_phase = (size32 == 32'd0) ? (n_pad ? P_PAD : P_HDR) : P_SKIP;
                    end
                end
            end
            P_FMT, P_FACT, P_DATA, P_SKIP: begin
                if (r_phase == P_FMT) begin
                    case (r_idx)
                        5'd0:  n_ftag[7:0]  = i_file_byte;
                        5'd1:  n_ftag[15:8] = i_file_byte;
                        5'd2:  n_chan[7:0]  = i_file_byte;
                        5'd3:  n_chan[15:8] = i_file_byte;
                        5'd12: n_blk[7:0]   = i_file_byte;
                        5'd13: n_blk[15:8]  = i_file_byte;
                        5'd14: n_bits[7:0]  = i_file_byte;
                        5'd15: n_bits[15:8] = i_file_byte;
                        default: ;
                    endcase
                    if (r_idx < 5'd31) n_idx = r_idx + 5'd1;
                end
                if (r_phase == P_FACT && r_idx < 5'd4) begin
                    n_fact = r_fact | (32'(i_file_byte) << {r_idx[1:0], 3'b000});
                    n_idx = r_idx + 5'd1;
                end
                if (r_phase == P_DATA) begin
                    if (in_sample) begin
                        if (kk == 32'd0) n_asm = '0;
                        if (kk < 32'(CAP) && kk < 32'd4)
                            n_asm = n_asm | (32'(i_file_byte) << {kk[1:0], 3'b000});
                        hit = last_k;
                    end
                    if (r_blk != 16'd0)
                        n_pos = (r_pos + 16'd1 == r_blk) ? 16'd0 : r_pos + 16'd1;
                end
                n_left = left_dec;
                if (left_dec == 33'd0) begin
                    n_idx = '0;
                    n_phase = r_pad ? P_PAD : P_HDR;
                end
            end
            P_PAD: begin
                n_idx = '0; n_phase = P_HDR;
            end
            default: ;
        endcase
    end

    assign o_status.sample_hit = i_cmd.step && hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_phase <= P_RIFF; r_idx <= '0; r_tag <= '0; r_left <= '0; r_pad <= 1'b0;
            r_ftag <= '0; r_chan <= '0; r_blk <= '0; r_bits <= '0;
            r_fmt_seen <= 1'b0; r_fact_seen <= 1'b0; r_fact <= '0; r_total <= '0;
            r_pos <= '0; r_asm <= '0; r_err <= ERR_NONE;
        end else if (i_cmd.step) begin
            r_phase <= n_phase; r_idx <= n_idx; r_tag <= n_tag; r_left <= n_left;
            r_pad <= n_pad; r_ftag <= n_ftag; r_chan <= n_chan; r_blk <= n_blk;
            r_bits <= n_bits; r_fmt_seen <= n_fmt_seen; r_fact_seen <= n_fact_seen;
            r_fact <= n_fact; r_total <= n_total; r_pos <= n_pos; r_asm <= n_asm;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && hit) begin
            r_flt  <= (r_ftag == FORMAT_FLOAT);
            r_word <= (r_ftag == FORMAT_FLOAT) ? n_asm : sx;
        end
    end

    // Length divider: (8*total) / (bits*channels), restoring, one bit a cycle.
    // The divisor is the 16x16 product of bits per sample and channel count,
    // formed in one multiply on start.
    logic [34:0] r_num;
    logic [31:0] r_den;
    logic [34:0] r_quo;
    logic [34:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_zero, r_use_fact;
    logic [35:0] trial;

    assign trial = {r_rem, r_num[34]} - 36'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_num      <= {n_total, 3'b000};
            r_den      <= 32'(n_bits) * 32'(n_chan);
            r_zero     <= (n_bits == 16'd0) || (n_chan == 16'd0);
            r_use_fact <= n_fact_seen;
            r_rem      <= '0;
            r_quo      <= '0;
            r_cnt      <= 6'd35;
        end else if (i_cmd.div_step && r_cnt != 6'd0) begin
            r_num <= {r_num[33:0], 1'b0};
            if (!trial[35]) begin
                r_rem <= trial[34:0];
                r_quo <= {r_quo[33:0], 1'b1};
            end else begin
                r_rem <= {r_rem[33:0], r_num[34]};
                r_quo <= {r_quo[33:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
        end
    end

    assign o_status.div_done = (r_cnt == 6'd0);

    assign o_sample_word     = r_word;
    assign o_sample_is_float = r_flt;
    assign o_error_code      = r_err;
    assign o_sample_length   = r_use_fact ? r_fact :
                               r_zero ? 32'd0 :
                               (r_quo[34:32] != 3'd0) ? 32'hFFFF_FFFF : r_quo[31:0];

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 6'd35) else $error("divider count out of range");
    a_step_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> i_cmd.step) else $error("division without last byte");
    a_div_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> (r_cnt == 6'd35)) else $error("divider not loaded");

endmodule

>>> hdl/wave_riff_stream_parser_core.sv
// WAVE file byte-stream parser.
// Input channel: one file byte per transaction (i_file_byte, i_final_byte),
// handshake i_valid/o_ready. Output channel: result transactions on
// o_valid/i_ready carrying o_result_kind (0 sample, 1 end-of-file report),
// o_sample_word, o_sample_is_float, o_error_code and o_sample_length.
// The byte is parsed in the cycle it is accepted, so after a byte that
// completes no sample and is not the final byte the next byte may follow
// straight away. A byte that completes a sample holds the input until that
// sample is taken. The final byte starts a restoring divider for the length,
// one quotient bit per cycle in 35 steps; the report is presented once the
// division completes, after the final byte or after the sample that byte
// completes has been taken.
// While a result waits for i_ready nothing more is accepted and all state
// holds.
// Reset (i_rst_n low, synchronous) clears the parser and the channel
// selection; after each report the parser returns to its reset state but
// keeps the selection written through i_cfg_we/i_cfg_data.
module wave_riff_stream_parser_core #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_file_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [31:0] o_sample_word,
    output logic        o_sample_is_float,
    output logic [2:0]  o_error_code,
    output logic [31:0] o_sample_length
);
    import wrsp_pkg::*;

    logic [15:0] r_sel;
    t_cmd        cmd;
    t_status     status;
    logic        kind;
    logic [31:0] word, len;
    logic [2:0]  err;
    logic        flt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0;
        end else if (i_cfg_we) begin
            r_sel <= i_cfg_data;
        end
    end

    wrsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_in_ready  (o_ready),
        .i_final     (i_final_byte),
        .o_valid     (o_valid),
        .i_out_ready (i_ready),
        .o_kind      (kind),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    wrsp_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_selected_channel (r_sel),
        .i_file_byte        (i_file_byte),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_sample_word      (word),
        .o_sample_is_float  (flt),
        .o_error_code       (err),
        .o_sample_length    (len)
    );

    // Fields that do not belong to a result kind read as zero.
    assign o_result_kind     = kind;
    assign o_sample_word     = kind ? 32'd0 : word;
    assign o_sample_is_float = kind ? 1'b0 : flt;
    assign o_error_code      = kind ? err : 3'd0;
    assign o_sample_length   = kind ? len : 32'd0;

endmodule
